>>> rtl/tsp_pkg.sv
`default_nettype none

package tsp_pkg;

   localparam int POS_BITS   = 32;
   localparam int FRAC_BITS  = 16;
   localparam int RATE_BITS  = 32;
   localparam int WIDE_BITS  = 2 * RATE_BITS;
   localparam int DEN_BITS   = RATE_BITS + FRAC_BITS + 1;
   localparam int BRAKE_BITS = 51;
   localparam int CLAMP_BITS = BRAKE_BITS + 2;
   localparam int ROOT_STEPS = WIDE_BITS / 2;
   localparam int DIV_STEPS  = WIDE_BITS;
   localparam int CNT_BITS   = $clog2(DIV_STEPS);
   localparam int QUEUE_DEPTH = 4;
   localparam int QIDX_BITS  = $clog2(QUEUE_DEPTH);

   localparam logic [BRAKE_BITS-1:0] BRAKE_SAT = {1'b1, {(BRAKE_BITS-1){1'b0}}};

   typedef enum logic [3:0] {
      OP_SET_TARGET = 4'd0,
      OP_SET_LOWER  = 4'd1,
      OP_SET_UPPER  = 4'd2,
      OP_JOG        = 4'd3,
      OP_GO         = 4'd4,
      OP_STOP       = 4'd5,
      OP_HALT       = 4'd6,
      OP_ZERO       = 4'd7,
      OP_TICK       = 4'd8,
      OP_REPORT     = 4'd9
   } op_type;

   typedef enum logic [2:0] {
      EV_TARGET      = 3'd0,
      EV_LIMITS      = 3'd1,
      EV_POSITION    = 3'd2,
      EV_MOVING      = 3'd3,
      EV_INTERRUPTED = 3'd4,
      EV_REQUEST     = 3'd5
   } event_type;

   typedef enum logic [1:0] {
      CSR_START_RATE  = 2'd0,
      CSR_CRUISE_RATE = 2'd1,
      CSR_ACCEL       = 2'd2
   } csr_type;

   typedef struct packed {
      logic                 start;
      logic                 divide;
      logic [WIDE_BITS-1:0] operand;
      logic [DEN_BITS-1:0]  divisor;
   } iter_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [WIDE_BITS-1:0] result;
      logic                 rem_nonzero;
   } iter_rsp_type;

   function automatic logic signed [POS_BITS-1:0] clamp_pos(
      input logic signed [CLAMP_BITS-1:0] v,
      input logic signed [POS_BITS-1:0]   lo,
      input logic signed [POS_BITS-1:0]   hi
   );
      logic signed [CLAMP_BITS-1:0] lo_w;
      logic signed [CLAMP_BITS-1:0] hi_w;
      logic signed [CLAMP_BITS-1:0] r;
      lo_w = CLAMP_BITS'(lo);
      hi_w = CLAMP_BITS'(hi);
      r = v;
      if (r > hi_w) r = hi_w;
      if (r < lo_w) r = lo_w;
      return r[POS_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/trapezoidal_step_profile_top.sv
// A tick may use a 32-step square root and a stop a 64-step division, both in the
// shared root/divide unit. Each request ends by draining the result queue, one result
// per cycle while the response side is not stalled; no request is taken meanwhile.
// Reset: synchronous; registers return to their defaults, motion state to zero.
`default_nettype none

module trapezoidal_step_profile_top (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  [3:0]                           req_op,
   input  wire  signed [tsp_pkg::POS_BITS-1:0]  req_value,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic [2:0]                           rsp_event_res,
   output logic signed [tsp_pkg::POS_BITS-1:0]  rsp_first_value,
   output logic signed [tsp_pkg::POS_BITS-1:0]  rsp_second_value,
   output logic                                 rsp_last,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [1:0]                           csr_index,
   input  wire  [tsp_pkg::RATE_BITS-1:0]        csr_data
);
   import tsp_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_LIMITS, S_RECLAMP, S_GO, S_HALT, S_HALT_MOVING,
      S_INTERRUPT, S_ZERO_LIMITS, S_ZERO_TARGET, S_ZERO_MOVING, S_REPORT_CHECK,
      S_TICK_SQUARE, S_TICK_PRODUCT, S_TICK_SUM, S_TICK_ROOT, S_TICK_RATE,
      S_TICK_STRIDE, S_STOP_SQUARE, S_STOP_START, S_STOP_NUM, S_STOP_DIV,
      S_STOP_TARGET, S_DRAIN
   } state_type;

   state_type state_ff, state_in;

   logic [RATE_BITS-1:0] start_ff, start_in;
   logic [RATE_BITS-1:0] cruise_ff, cruise_in;
   logic [RATE_BITS-1:0] accel_ff, accel_in;

   logic signed [POS_BITS-1:0] position_ff, position_in;
   logic signed [POS_BITS-1:0] target_ff, target_in;
   logic signed [POS_BITS-1:0] lower_ff, lower_in;
   logic signed [POS_BITS-1:0] upper_ff, upper_in;
   logic [RATE_BITS-1:0]       rate_ff, rate_in;
   logic [FRAC_BITS-1:0]       fraction_ff, fraction_in;
   logic                       moving_ff, moving_in;
   logic                       pending_ff, pending_in;
   logic signed [POS_BITS-1:0] stride_ff, stride_in;

   op_type                     op_ff, op_in;
   logic signed [POS_BITS-1:0] val_ff, val_in;
   logic                       intr_ff, intr_in;
   logic                       dir_ff, dir_in;
   logic [POS_BITS-1:0]        dist_ff, dist_in;
   logic [BRAKE_BITS-1:0]      brk_ff, brk_in;
   logic [WIDE_BITS-1:0]       wide_ff, wide_in;
   logic [WIDE_BITS-1:0]       prod_ff, prod_in;
   logic [RATE_BITS-1:0]       mul_a, mul_b;

   event_type                  q_ev_ff [QUEUE_DEPTH];
   logic signed [POS_BITS-1:0] q_a_ff  [QUEUE_DEPTH];
   logic signed [POS_BITS-1:0] q_b_ff  [QUEUE_DEPTH];
   logic [QIDX_BITS:0]         cnt_ff, cnt_in;
   logic [QIDX_BITS:0]         rd_ff, rd_in;
   logic                       push_en;
   event_type                  push_ev;
   logic signed [POS_BITS-1:0] push_a, push_b;

   logic                       rsp_valid_ff, rsp_valid_in;
   event_type                  rsp_ev_ff, rsp_ev_in;
   logic signed [POS_BITS-1:0] rsp_a_ff, rsp_a_in;
   logic signed [POS_BITS-1:0] rsp_b_ff, rsp_b_in;
   logic                       rsp_last_ff, rsp_last_in;

   iter_cmd_type               iter_cmd;
   iter_rsp_type               iter_rsp;

   logic signed [POS_BITS:0]     rem;
   logic [POS_BITS:0]            rem_abs;
   logic signed [POS_BITS-1:0]   pos_new;
   logic signed [CLAMP_BITS-1:0] wide_v;
   logic [WIDE_BITS:0]           root_sum;
   logic                         root_ovf;
   logic [BRAKE_BITS-1:0]        rate_acc, rate_r;
   logic [RATE_BITS:0]           frac_sum;
   logic [POS_BITS-1:0]          step;
   logic [WIDE_BITS-1:0]         num, quot;
   logic                         accept, out_free;

   tsp_root_div u_root_div (
      .clock (clock),
      .reset (reset),
      .cmd   (iter_cmd),
      .rsp   (iter_rsp)
   );

   always_comb begin
      case (state_ff)
         S_TICK_SQUARE:  begin mul_a = start_ff; mul_b = start_ff; end
         S_TICK_PRODUCT: begin mul_a = accel_ff; mul_b = dist_ff;  end
         S_STOP_SQUARE:  begin mul_a = rate_ff;  mul_b = rate_ff;  end
         default:        begin mul_a = start_ff; mul_b = start_ff; end
      endcase
      prod_in = WIDE_BITS'(mul_a) * WIDE_BITS'(mul_b);
   end

   always_comb begin
      accept   = req_valid && (state_ff == S_IDLE);
      out_free = !rsp_valid_ff || !rsp_stall;

      rem      = $signed({target_ff[POS_BITS-1], target_ff})
               - $signed({position_ff[POS_BITS-1], position_ff});
      rem_abs  = rem[POS_BITS] ? -rem : rem;
      pos_new  = position_ff + val_ff;
      root_ovf = |prod_ff[WIDE_BITS-1:WIDE_BITS-FRAC_BITS-1];
      root_sum = {1'b0, wide_ff} + {1'b0, prod_ff[WIDE_BITS-FRAC_BITS-2:0], {(FRAC_BITS+1){1'b0}}};
      num      = (wide_ff > prod_ff) ? wide_ff - prod_ff : '0;
      quot     = iter_rsp.result + WIDE_BITS'(iter_rsp.rem_nonzero);
      rate_acc = BRAKE_BITS'(rate_ff) + BRAKE_BITS'(accel_ff);
      rate_r   = BRAKE_BITS'(cruise_ff);
      if (rate_acc < rate_r) rate_r = rate_acc;
      if (brk_ff < rate_r) rate_r = brk_ff;
      if (rate_r < BRAKE_BITS'(start_ff)) rate_r = BRAKE_BITS'(start_ff);
      frac_sum = {1'b0, rate_ff} + (RATE_BITS+1)'(fraction_ff);
      step     = POS_BITS'(frac_sum[RATE_BITS:FRAC_BITS]);
      if (step > dist_ff) step = dist_ff;
      wide_v   = dir_ff ? CLAMP_BITS'(position_ff) + $signed({2'b00, brk_ff})
                        : CLAMP_BITS'(position_ff) - $signed({2'b00, brk_ff});

      state_in    = state_ff;
      start_in    = start_ff;
      cruise_in   = cruise_ff;
      accel_in    = accel_ff;
      position_in = position_ff;
      target_in   = target_ff;
      lower_in    = lower_ff;
      upper_in    = upper_ff;
      rate_in     = rate_ff;
      fraction_in = fraction_ff;
      moving_in   = moving_ff;
      pending_in  = pending_ff;
      stride_in   = stride_ff;
      op_in       = op_ff;
      val_in      = val_ff;
      intr_in     = intr_ff;
      dir_in      = dir_ff;
      dist_in     = dist_ff;
      brk_in      = brk_ff;
      wide_in     = wide_ff;
      cnt_in      = cnt_ff;
      rd_in       = rd_ff;
      push_en     = 1'b0;
      push_ev     = EV_TARGET;
      push_a      = '0;
      push_b      = '0;
      iter_cmd    = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ev_in    = rsp_ev_ff;
      rsp_a_in     = rsp_a_ff;
      rsp_b_in     = rsp_b_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_START_RATE:  start_in  = csr_data;
            CSR_CRUISE_RATE: cruise_in = csr_data;
            CSR_ACCEL:       accel_in  = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = op_type'(req_op);
               val_in   = req_value;
               intr_in  = 1'b0;
               cnt_in   = '0;
               rd_in    = '0;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_DRAIN;
            case (op_ff)
               OP_SET_TARGET: begin
                  target_in = clamp_pos(CLAMP_BITS'(val_ff), lower_ff, upper_ff);
                  push_en = 1'b1; push_ev = EV_TARGET; push_a = target_in;
               end
               OP_SET_LOWER: begin
                  lower_in = val_ff;
                  if (val_ff > upper_ff) upper_in = val_ff;
                  state_in = S_LIMITS;
               end
               OP_SET_UPPER: begin
                  upper_in = val_ff;
                  if (val_ff < lower_ff) lower_in = val_ff;
                  state_in = S_LIMITS;
               end
               OP_JOG: begin
                  target_in = clamp_pos(CLAMP_BITS'(moving_ff ? target_ff : position_ff)
                                        + CLAMP_BITS'(val_ff), lower_ff, upper_ff);
                  push_en = 1'b1; push_ev = EV_TARGET; push_a = target_in;
                  state_in = S_GO;
               end
               OP_GO: state_in = S_GO;
               OP_STOP: begin
                  if (moving_ff) begin
                     dir_in   = target_ff >= position_ff;
                     state_in = S_STOP_SQUARE;
                  end
               end
               OP_HALT: state_in = S_HALT;
               OP_ZERO: begin
                  position_in = '0;
                  target_in   = target_ff - position_ff;
                  lower_in    = lower_ff - position_ff;
                  upper_in    = upper_ff - position_ff;
                  push_en = 1'b1; push_ev = EV_POSITION;
                  state_in = S_ZERO_LIMITS;
               end
               OP_TICK: begin
                  if (moving_ff && !pending_ff) begin
                     if (rem == '0) begin
                        state_in = S_HALT;
                     end else begin
                        dir_in   = !rem[POS_BITS];
                        dist_in  = rem_abs[POS_BITS-1:0];
                        state_in = S_TICK_SQUARE;
                     end
                  end
               end
               OP_REPORT: begin
                  if (pending_ff) begin
                     pending_in  = 1'b0;
                     position_in = pos_new;
                     push_en = 1'b1; push_ev = EV_POSITION; push_a = pos_new;
                     state_in = S_REPORT_CHECK;
                  end
               end
               default: ;
            endcase
         end
         S_LIMITS: begin
            push_en = 1'b1; push_ev = EV_LIMITS; push_a = lower_ff; push_b = upper_ff;
            state_in = S_RECLAMP;
         end
         S_RECLAMP: begin
            target_in = clamp_pos(CLAMP_BITS'(target_ff), lower_ff, upper_ff);
            push_en = 1'b1; push_ev = EV_TARGET; push_a = target_in;
            state_in = S_DRAIN;
         end
         S_GO: begin
            if (position_ff != target_ff && !moving_ff) begin
               rate_in     = start_ff;
               fraction_in = '0;
               moving_in   = 1'b1;
               push_en = 1'b1; push_ev = EV_MOVING; push_a = 32'sd1;
            end
            state_in = S_DRAIN;
         end
         S_HALT: begin
            moving_in = 1'b0;
            target_in = clamp_pos(CLAMP_BITS'(position_ff), lower_ff, upper_ff);
            push_en = 1'b1; push_ev = EV_TARGET; push_a = target_in;
            state_in = S_HALT_MOVING;
         end
         S_HALT_MOVING: begin
            push_en = 1'b1; push_ev = EV_MOVING;
            state_in = intr_ff ? S_INTERRUPT : S_DRAIN;
         end
         S_INTERRUPT: begin
            push_en = 1'b1; push_ev = EV_INTERRUPTED;
            state_in = S_DRAIN;
         end
         S_ZERO_LIMITS: begin
            push_en = 1'b1; push_ev = EV_LIMITS; push_a = lower_ff; push_b = upper_ff;
            state_in = S_ZERO_TARGET;
         end
         S_ZERO_TARGET: begin
            push_en = 1'b1; push_ev = EV_TARGET; push_a = target_ff;
            state_in = S_ZERO_MOVING;
         end
         S_ZERO_MOVING: begin
            push_en = 1'b1; push_ev = EV_MOVING; push_a = POS_BITS'(moving_ff);
            state_in = S_DRAIN;
         end
         S_REPORT_CHECK: begin
            state_in = S_DRAIN;
            if (val_ff != stride_ff) begin
               intr_in  = 1'b1;
               state_in = S_HALT;
            end else if (position_ff == target_ff && moving_ff) begin
               moving_in = 1'b0;
               push_en = 1'b1; push_ev = EV_MOVING;
            end
         end
         S_TICK_SQUARE:  state_in = S_TICK_PRODUCT;
         S_TICK_PRODUCT: begin
            wide_in  = prod_ff;
            state_in = S_TICK_SUM;
         end
         S_TICK_SUM: begin
            if (root_ovf || root_sum[WIDE_BITS]) begin
               brk_in   = BRAKE_BITS'({RATE_BITS{1'b1}});
               state_in = S_TICK_RATE;
            end else begin
               iter_cmd.start   = 1'b1;
               iter_cmd.operand = root_sum[WIDE_BITS-1:0];
               state_in = S_TICK_ROOT;
            end
         end
         S_TICK_ROOT: begin
            if (iter_rsp.done) begin
               brk_in   = BRAKE_BITS'(iter_rsp.result[RATE_BITS-1:0]);
               state_in = S_TICK_RATE;
            end
         end
         S_TICK_RATE: begin
            rate_in  = rate_r[RATE_BITS-1:0];
            state_in = S_TICK_STRIDE;
         end
         S_TICK_STRIDE: begin
            fraction_in = frac_sum[FRAC_BITS-1:0];
            state_in    = S_DRAIN;
            if (step != '0) begin
               pending_in = 1'b1;
               stride_in  = dir_ff ? $signed(step) : -$signed(step);
               push_en = 1'b1; push_ev = EV_REQUEST; push_a = stride_in;
            end
         end
         S_STOP_SQUARE: state_in = S_STOP_START;
         S_STOP_START: begin
            wide_in  = prod_ff;
            state_in = S_STOP_NUM;
         end
         S_STOP_NUM: begin
            state_in = S_STOP_TARGET;
            if (num == '0) begin
               brk_in = '0;
            end else if (accel_ff == '0) begin
               brk_in = BRAKE_SAT;
            end else begin
               iter_cmd.start   = 1'b1;
               iter_cmd.divide  = 1'b1;
               iter_cmd.operand = num;
               iter_cmd.divisor = {accel_ff, {(FRAC_BITS+1){1'b0}}};
               state_in = S_STOP_DIV;
            end
         end
         S_STOP_DIV: begin
            if (iter_rsp.done) begin
               brk_in   = (quot > WIDE_BITS'(BRAKE_SAT)) ? BRAKE_SAT
                                                          : quot[BRAKE_BITS-1:0];
               state_in = S_STOP_TARGET;
            end
         end
         S_STOP_TARGET: begin
            target_in = clamp_pos(wide_v, lower_ff, upper_ff);
            push_en = 1'b1; push_ev = EV_TARGET; push_a = target_in;
            state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (rd_ff == cnt_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ev_in    = q_ev_ff[rd_ff[QIDX_BITS-1:0]];
               rsp_a_in     = q_a_ff[rd_ff[QIDX_BITS-1:0]];
               rsp_b_in     = q_b_ff[rd_ff[QIDX_BITS-1:0]];
               rsp_last_in  = (rd_ff + 1'b1) == cnt_ff;
               rd_in        = rd_ff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (push_en) cnt_in = cnt_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= RATE_BITS'(65536);
         cruise_ff    <= RATE_BITS'(1048576);
         accel_ff     <= RATE_BITS'(3277);
         position_ff  <= '0;
         target_ff    <= '0;
         lower_ff     <= '0;
         upper_ff     <= '0;
         rate_ff      <= '0;
         fraction_ff  <= '0;
         moving_ff    <= 1'b0;
         pending_ff   <= 1'b0;
         stride_ff    <= '0;
         cnt_ff       <= '0;
         rd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         cruise_ff    <= cruise_in;
         accel_ff     <= accel_in;
         position_ff  <= position_in;
         target_ff    <= target_in;
         lower_ff     <= lower_in;
         upper_ff     <= upper_in;
         rate_ff      <= rate_in;
         fraction_ff  <= fraction_in;
         moving_ff    <= moving_in;
         pending_ff   <= pending_in;
         stride_ff    <= stride_in;
         cnt_ff       <= cnt_in;
         rd_ff        <= rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      val_ff      <= val_in;
      intr_ff     <= intr_in;
      dir_ff      <= dir_in;
      dist_ff     <= dist_in;
      brk_ff      <= brk_in;
      wide_ff     <= wide_in;
      prod_ff     <= prod_in;
      rsp_ev_ff   <= rsp_ev_in;
      rsp_a_ff    <= rsp_a_in;
      rsp_b_ff    <= rsp_b_in;
      rsp_last_ff <= rsp_last_in;
      if (push_en) begin
         q_ev_ff[cnt_ff[QIDX_BITS-1:0]] <= push_ev;
         q_a_ff[cnt_ff[QIDX_BITS-1:0]]  <= push_a;
         q_b_ff[cnt_ff[QIDX_BITS-1:0]]  <= push_b;
      end
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_res    = rsp_ev_ff;
   assign rsp_first_value  = rsp_a_ff;
   assign rsp_second_value = rsp_b_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

`default_nettype wire

>>> rtl/tsp_root_div.sv
`default_nettype none

module tsp_root_div (
   input  wire                    clock,
   input  wire                    reset,
   input  tsp_pkg::iter_cmd_type  cmd,
   output tsp_pkg::iter_rsp_type  rsp
);
   import tsp_pkg::*;

   localparam logic [WIDE_BITS-1:0] ROOT_BIT = {2'b01, {(WIDE_BITS-2){1'b0}}};
   localparam logic [CNT_BITS-1:0]  ROOT_LAST = CNT_BITS'(ROOT_STEPS - 1);
   localparam logic [CNT_BITS-1:0]  DIV_LAST  = CNT_BITS'(DIV_STEPS - 1);

   logic                 active_ff, active_in;
   logic                 done_ff, done_in;
   logic                 divide_ff, divide_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [WIDE_BITS-1:0] acc_ff, acc_in;
   logic [WIDE_BITS-1:0] res_ff, res_in;
   logic [WIDE_BITS-1:0] bit_ff, bit_in;
   logic [DEN_BITS-1:0]  den_ff, den_in;

   logic [WIDE_BITS-1:0] root_try;
   logic                 root_ok;
   logic [WIDE_BITS-1:0] div_shift;
   logic                 div_ok;
   logic [CNT_BITS-1:0]  last_count;

   always_comb begin
      root_try   = res_ff + bit_ff;
      root_ok    = acc_ff >= root_try;
      div_shift  = {acc_ff[WIDE_BITS-2:0], bit_ff[WIDE_BITS-1]};
      div_ok     = div_shift >= WIDE_BITS'(den_ff);
      last_count = divide_ff ? DIV_LAST : ROOT_LAST;

      active_in = active_ff;
      done_in   = 1'b0;
      divide_in = divide_ff;
      count_in  = count_ff;
      acc_in    = acc_ff;
      res_in    = res_ff;
      bit_in    = bit_ff;
      den_in    = den_ff;

      if (cmd.start) begin
         active_in = 1'b1;
         divide_in = cmd.divide;
         count_in  = '0;
         res_in    = '0;
         den_in    = cmd.divisor;
         if (cmd.divide) begin
            acc_in = '0;
            bit_in = cmd.operand;
         end else begin
            acc_in = cmd.operand;
            bit_in = ROOT_BIT;
         end
      end else if (active_ff) begin
         count_in = count_ff + 1'b1;
         if (divide_ff) begin
            acc_in = div_ok ? div_shift - WIDE_BITS'(den_ff) : div_shift;
            res_in = {res_ff[WIDE_BITS-2:0], div_ok};
            bit_in = {bit_ff[WIDE_BITS-2:0], 1'b0};
         end else begin
            if (root_ok) begin
               acc_in = acc_ff - root_try;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
         end
         if (count_ff == last_count) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      divide_ff <= divide_in;
      count_ff  <= count_in;
      acc_ff    <= acc_in;
      res_ff    <= res_in;
      bit_ff    <= bit_in;
      den_ff    <= den_in;
   end

   assign rsp.done        = done_ff;
   assign rsp.result      = res_ff;
   assign rsp.rem_nonzero = |acc_ff;

endmodule

`default_nettype wire
